/* sv/vtx_pkg.sv */
// Shared types and constants for the 4x4 vertex transform.
// Used by the channel interfaces, the column cells, the output stage and the top level.
package vtx_pkg;

  localparam int DIM       = 4;
  localparam int IDX_W     = $clog2(DIM);
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + IDX_W;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef acc_t  acc_vec_t [DIM];
  typedef prod_t prod_vec_t [DIM];

  // Request moving down the cell chain
  typedef struct packed {
    logic                            valid;
    logic                            load;
    logic [IDX_W-1:0]                row;
    logic [IDX_W-1:0]                col;
    logic [DATA_W-1:0]               value;
    logic [DIM-1:0][DATA_W-1:0]      vec;
  } tok_t;

endpackage

/* sv/vtx_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on vtx_pkg for field widths.
interface vtx_req_if;
  import vtx_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  entry_row;
  logic [IDX_W-1:0]  entry_col;
  word_t             entry_value;
  word_t             vec_x;
  word_t             vec_y;
  word_t             vec_z;
  word_t             vec_w;

  modport source (
    output valid, req_type, entry_row, entry_col, entry_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_row, entry_col, entry_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface vtx_res_if;
  import vtx_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_x;
  word_t out_y;
  word_t out_z;
  word_t out_w;
  logic  saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

/* sv/vertex_transform_4x4_top.sv */
// 4x4 matrix times vector in signed Q16.16, built as a chain of four column cells.
// A transform request passes each cell's multiply and accumulate registers, then the output register.
// Throughput: one request per cycle while no result is stalled; each cell has a multiply and an accumulate stage.
// Load requests travel down the same chain and write their column in order; no result.
// A stalled result holds the whole chain. Reset (rst, synchronous) clears the matrix
// to all zeros and empties the chain; no request is taken during reset.
module vertex_transform_4x4_top (
  input logic      clk,
  input logic      rst,
  vtx_req_if.sink  req,
  vtx_res_if.source res
);
  import vtx_pkg::*;

  logic     en;
  tok_t     tok_chain [DIM+1];
  acc_vec_t acc_chain [DIM+1];

  // Advance the whole chain unless a result is waiting
  assign en        = !res.valid || res.ready;
  assign req.ready = en && !rst;

  // Pack the incoming request
  always_comb begin
    tok_chain[0].valid  = req.valid;
    tok_chain[0].load   = (req.req_type == REQ_LOAD);
    tok_chain[0].row    = req.entry_row;
    tok_chain[0].col    = req.entry_col;
    tok_chain[0].value  = req.entry_value;
    tok_chain[0].vec[0] = req.vec_x;
    tok_chain[0].vec[1] = req.vec_y;
    tok_chain[0].vec[2] = req.vec_z;
    tok_chain[0].vec[3] = req.vec_w;
    for (int r = 0; r < DIM; r++) begin
      acc_chain[0][r] = '0;
    end
  end

  // Column cells
  for (genvar c = 0; c < DIM; c++) begin : g_cell
    vtx_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .col_idx (IDX_W'(c)),
      .tok_in  (tok_chain[c]),
      .acc_in  (acc_chain[c]),
      .tok_out (tok_chain[c+1]),
      .acc_out (acc_chain[c+1])
    );
  end

  // Shift, saturate and register the result; drop load requests here
  vtx_sat u_sat (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .xform_valid (tok_chain[DIM].valid && !tok_chain[DIM].load),
    .acc_in      (acc_chain[DIM]),
    .valid       (res.valid),
    .out_x       (res.out_x),
    .out_y       (res.out_y),
    .out_z       (res.out_z),
    .out_w       (res.out_w),
    .saturated   (res.saturated)
  );

endmodule

/* sv/vtx_cell.sv */
// One column cell: holds one matrix column, multiplies it by its vector component
// and adds the products to the passing row sums. Depends on vtx_pkg.
module vtx_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [vtx_pkg::IDX_W-1:0] col_idx,
  input  vtx_pkg::tok_t             tok_in,
  input  vtx_pkg::acc_vec_t         acc_in,
  output vtx_pkg::tok_t             tok_out,
  output vtx_pkg::acc_vec_t         acc_out
);
  import vtx_pkg::*;

  logic [DIM-1:0][DATA_W-1:0] col_m;
  tok_t                       tok_a;
  tok_t                       tok_b;
  acc_vec_t                   acc_a;
  acc_vec_t                   acc_b;
  prod_vec_t                  prod_a;
  logic                       col_wr;
  word_t                      vcomp;

  assign col_wr = en && tok_in.valid && tok_in.load && (tok_in.col == col_idx);
  assign vcomp  = $signed(tok_in.vec[col_idx]);

  // Write this cell's column when a load request passes
  always_ff @(posedge clk) begin
    if (rst) begin
      col_m <= '0;
    end else if (col_wr) begin
      col_m[tok_in.row] <= tok_in.value;
    end
  end

  // Multiply stage: hold request, incoming sums and products
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a.valid <= 1'b0;
    end else if (en) begin
      tok_a <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        acc_a[r]  <= acc_in[r];
        prod_a[r] <= prod_t'($signed(col_m[r])) * prod_t'(vcomp);
      end
    end
  end

  // Accumulate stage: add the products into the row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_b.valid <= 1'b0;
    end else if (en) begin
      tok_b <= tok_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        acc_b[r] <= acc_a[r] + acc_t'(prod_a[r]);
      end
    end
  end

  assign tok_out = tok_b;
  assign acc_out = acc_b;

`ifndef SYNTHESIS
  a_col_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(col_wr) |-> col_m == $past(col_m))
    else $error("column changed without a load request for this column");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(en) |-> tok_b.valid == $past(tok_b.valid) &&
                                   tok_a.valid == $past(tok_a.valid))
    else $error("cell stages moved while stalled");
`endif

endmodule

/* sv/vtx_sat.sv */
// Output stage: shifts the row sums down by the fraction width, saturates
// to 32 bits and registers the result. Depends on vtx_pkg.
module vtx_sat (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              xform_valid,
  input  vtx_pkg::acc_vec_t acc_in,
  output logic              valid,
  output vtx_pkg::word_t    out_x,
  output vtx_pkg::word_t    out_y,
  output vtx_pkg::word_t    out_z,
  output vtx_pkg::word_t    out_w,
  output logic              saturated
);
  import vtx_pkg::*;

  word_t           comp_next [DIM];
  logic  [DIM-1:0] clip;
  acc_t            shifted [DIM];
  word_t           res [DIM];
  logic            sat_flag;

  // Floor shift, then clip anything outside the 32-bit range
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      shifted[r] = acc_in[r] >>> FRAC_BITS;
      clip[r]    = !((&shifted[r][ACC_W-1:DATA_W-1]) || !(|shifted[r][ACC_W-1:DATA_W-1]));
      if (clip[r]) begin
        comp_next[r] = shifted[r][ACC_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        comp_next[r] = shifted[r][DATA_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= xform_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        res[r] <= comp_next[r];
      end
      sat_flag <= |clip;
    end
  end

  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];
  assign saturated = sat_flag;

`ifndef SYNTHESIS
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    valid && saturated |->
      out_x == WORD_MAX || out_x == WORD_MIN || out_y == WORD_MAX || out_y == WORD_MIN ||
      out_z == WORD_MAX || out_z == WORD_MIN || out_w == WORD_MAX || out_w == WORD_MIN)
    else $error("saturated flag set but no component sits at a limit");

  a_xform_lands: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(en) && $past(xform_valid) |-> valid)
    else $error("transform request lost at the output stage");
`endif

endmodule
